@@ src/control_ownership_handoff_guard_unit_assert.svh @@
`ifndef CONTROL_OWNERSHIP_HANDOFF_GUARD_UNIT_ASSERT_SVH
`define CONTROL_OWNERSHIP_HANDOFF_GUARD_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define COHG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define COHG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cohg_pkg.sv @@
package cohg_pkg;

    // field widths
    localparam int unsigned AXIS_W   = 3;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned EV_W     = 7;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned IN_DATA_W  = 240;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FB_MAX_AGE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_TIMEOUT = 1'd1;

    localparam logic [CFG_W-1:0] FB_MAX_AGE_RST  = 32'd20000;
    localparam logic [CFG_W-1:0] REL_TIMEOUT_RST = 32'd500000;

    // evidence bit positions
    localparam int unsigned EV_FRESH      = 0;
    localparam int unsigned EV_LCD_IDLE   = 1;
    localparam int unsigned EV_BUS_IDLE   = 2;
    localparam int unsigned EV_DISABLED   = 3;
    localparam int unsigned EV_NO_FAULT   = 4;
    localparam int unsigned EV_STATIONARY = 5;
    localparam int unsigned EV_DISCOVERED = 6;

    // evidence needed to hand over, and to take back
    localparam logic [EV_W-1:0] EV_ACQ_MASK = 7'b111_1110;
    localparam logic [EV_W-1:0] EV_REL_MASK = 7'b011_1100;

    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_REPORT  = 2'd2,
        REQ_SERVICE = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_ARG     = 4'd1,
        ST_BUSY        = 4'd2,
        ST_STALE       = 4'd3,
        ST_UNSAFE      = 4'd4,
        ST_TRANSFERRED = 4'd5,
        ST_RELEASED    = 4'd6,
        ST_TIMEOUT     = 4'd7,
        ST_WAITING     = 4'd8,
        ST_RECORDED    = 4'd9,
        ST_IGNORED     = 4'd10
    } t_status;

    typedef enum logic [3:0] {
        MODE_MANUAL     = 4'b0001,
        MODE_ACQUIRING  = 4'b0010,
        MODE_CONTROLLER = 4'b0100,
        MODE_RELEASING  = 4'b1000
    } t_mode;

    localparam logic [1:0] CODE_MANUAL     = 2'd0;
    localparam logic [1:0] CODE_ACQUIRING  = 2'd1;
    localparam logic [1:0] CODE_CONTROLLER = 2'd2;
    localparam logic [1:0] CODE_RELEASING  = 2'd3;

    // one-hot state to the reported owner code
    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            MODE_MANUAL:     c = CODE_MANUAL;
            MODE_ACQUIRING:  c = CODE_ACQUIRING;
            MODE_CONTROLLER: c = CODE_CONTROLLER;
            MODE_RELEASING:  c = CODE_RELEASING;
            default:         c = CODE_MANUAL;
        endcase
        return c;
    endfunction

endpackage

@@ src/control_ownership_handoff_guard_unit.sv @@
// ownership guard for handing motor control between a manual owner and a
// closed-loop controller (manual, acquiring, controller, releasing). each
// input beat is one request: acquire, release, disable transmit report or
// service with evidence, selected by s_axis_tuser; each gives exactly one
// result beat with a status and the owner state, axis and request id after
// it. throughput is one beat per clock while the result stream is not
// stalled; a taken beat lands in the input register and then moves
// through the single decision stage into the result register, which
// also updates the owner state so that the next beat sees it. feedback
// counts only when marked fresh, nonzero, not in the future and within
// feedback_max_age_us (cfg index 0); a release completes only on such
// feedback newer than a recorded disable transmission, and waiting
// longer than release_timeout_us (cfg index 1) is reported as timeout
// without changing state. config must be written only while idle by the
// user; the block itself does not enforce it.
module control_ownership_handoff_guard_unit #(
    parameter int unsigned AXIS_COUNT = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [cohg_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [cohg_pkg::CFG_W-1:0]         i_cfg_wdata,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // axis_number, request_number, time_now_us, feedback_time_us,
    // transmit_time_us, transmit_ok, evidence_bits, zero pad
    input  logic [cohg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic [cohg_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status_code, owner_state, owner_axis, current_request, zero pad
    output logic [cohg_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import cohg_pkg::*;

    // config registers
    logic [CFG_W-1:0] r_fb_max_age;
    logic [CFG_W-1:0] r_rel_timeout;

    // input register
    logic              r_in_valid;
    t_req              r_in_type;
    logic [AXIS_W-1:0] r_in_axis;
    logic [ID_W-1:0]   r_in_req;
    logic [TIME_W-1:0] r_in_now;
    logic [TIME_W-1:0] r_in_fb;
    logic [TIME_W-1:0] r_in_tx;
    logic              r_in_ok;
    logic [EV_W-1:0]   r_in_ev;

    // owner state; the active id is also the highest id accepted, since only
    // accepted acquire and release requests set it; one register serves both
    t_mode             r_mode;
    logic [AXIS_W-1:0] r_axis;
    logic [ID_W-1:0]   r_active_id;
    logic [TIME_W-1:0] r_rel_start;
    logic [TIME_W-1:0] r_dis_sent;

    t_mode             n_mode;
    logic [AXIS_W-1:0] n_axis;
    logic [ID_W-1:0]   n_active_id;
    logic [TIME_W-1:0] n_rel_start;
    logic [TIME_W-1:0] n_dis_sent;
    t_status           n_status;

    // result register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [1:0]        r_out_mode;
    logic [AXIS_W-1:0] r_out_axis;
    logic [ID_W-1:0]   r_out_req;

    logic w_advance;
    logic w_step;
    logic w_in_take;

    logic [TIME_W-1:0] w_fb_age;
    logic [TIME_W-1:0] w_rel_wait;
    logic              w_fb_current;
    logic              w_timed_out;
    logic              w_release_done;
    logic              w_handover_ok;
    logic              w_axis_bad;

    // handshake: a held request moves on when the result slot is free or draining
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_req, r_out_axis, r_out_mode, r_out_status};

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_max_age  <= FB_MAX_AGE_RST;
            r_rel_timeout <= REL_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FB_MAX_AGE:  r_fb_max_age  <= i_cfg_wdata;
                CFG_REL_TIMEOUT: r_rel_timeout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register: payload unpacked from the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_type <= t_req'(s_axis_tuser);
            r_in_axis <= s_axis_tdata[2:0];
            r_in_req  <= s_axis_tdata[34:3];
            r_in_now  <= s_axis_tdata[98:35];
            r_in_fb   <= s_axis_tdata[162:99];
            r_in_tx   <= s_axis_tdata[226:163];
            r_in_ok   <= s_axis_tdata[227];
            r_in_ev   <= s_axis_tdata[234:228];
        end
    end

    // timing checks, all in parallel
    assign w_fb_age     = r_in_now - r_in_fb;
    assign w_rel_wait   = r_in_now - r_rel_start;
    assign w_fb_current = r_in_ev[EV_FRESH] && (r_in_fb != '0) && (r_in_now >= r_in_fb)
                          && (w_fb_age <= {32'd0, r_fb_max_age});
    assign w_timed_out  = (r_in_now >= r_rel_start)
                          && (w_rel_wait > {32'd0, r_rel_timeout});
    assign w_handover_ok  = w_fb_current && ((r_in_ev & EV_ACQ_MASK) == EV_ACQ_MASK);
    // feedback must postdate the recorded disable transmission
    assign w_release_done = (r_dis_sent != '0) && w_fb_current && (r_in_fb > r_dis_sent)
                            && ((r_in_ev & EV_REL_MASK) == EV_REL_MASK);
    assign w_axis_bad     = {1'b0, r_in_axis} >= 4'(AXIS_COUNT);

    // decision stage
    always_comb begin
        n_mode      = r_mode;
        n_axis      = r_axis;
        n_active_id = r_active_id;
        n_rel_start = r_rel_start;
        n_dis_sent  = r_dis_sent;
        n_status    = ST_WAITING;
        unique case (r_in_type)
            REQ_ACQUIRE: begin
                if (w_axis_bad || r_in_req == '0) begin
                    n_status = ST_BAD_ARG;
                end else if (r_mode != MODE_MANUAL) begin
                    n_status = ST_BUSY;
                end else if (r_in_req <= r_active_id) begin
                    n_status = ST_STALE;
                end else begin
                    n_axis      = r_in_axis;
                    n_active_id = r_in_req;
                    n_mode      = MODE_ACQUIRING;
                    n_status    = ST_OK;
                end
            end
            REQ_RELEASE: begin
                // note stale is checked ahead of busy here
                if (r_in_req == '0 || r_in_now == '0) begin
                    n_status = ST_BAD_ARG;
                end else if (r_in_req <= r_active_id) begin
                    n_status = ST_STALE;
                end else if (r_mode != MODE_CONTROLLER) begin
                    n_status = ST_BUSY;
                end else begin
                    n_active_id = r_in_req;
                    n_rel_start = r_in_now;
                    n_dis_sent  = '0;
                    n_mode      = MODE_RELEASING;
                    n_status    = ST_OK;
                end
            end
            REQ_REPORT: begin
                if (r_mode == MODE_RELEASING && r_in_ok && r_in_tx >= r_rel_start) begin
                    n_dis_sent = r_in_tx;
                    n_status   = ST_RECORDED;
                end else begin
                    n_status = ST_IGNORED;
                end
            end
            REQ_SERVICE: begin
                unique case (r_mode)
                    MODE_ACQUIRING: begin
                        if (w_handover_ok) begin
                            n_mode   = MODE_CONTROLLER;
                            n_status = ST_TRANSFERRED;
                        end else begin
                            n_mode   = MODE_MANUAL;
                            n_status = ST_UNSAFE;
                        end
                    end
                    MODE_RELEASING: begin
                        if (w_release_done) begin
                            n_mode   = MODE_MANUAL;
                            n_status = ST_RELEASED;
                        end else if (w_timed_out) begin
                            // reported only, release keeps waiting
                            n_status = ST_TIMEOUT;
                        end else begin
                            n_status = ST_WAITING;
                        end
                    end
                    default: n_status = ST_WAITING;
                endcase
            end
            default: n_status = ST_IGNORED;
        endcase
    end

    // owner state update, one step per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MANUAL;
            r_axis      <= '0;
            r_active_id <= '0;
            r_rel_start <= '0;
            r_dis_sent  <= '0;
        end else if (w_step) begin
            r_mode      <= n_mode;
            r_axis      <= n_axis;
            r_active_id <= n_active_id;
            r_rel_start <= n_rel_start;
            r_dis_sent  <= n_dis_sent;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_status <= n_status;
            r_out_mode   <= mode_code(n_mode);
            r_out_axis   <= n_axis;
            r_out_req    <= n_active_id;
        end
    end

`include "control_ownership_handoff_guard_unit_assert.svh"

    // request ids only ever move upwards
    `COHG_ASSERT_NOW(a_id_monotonic, i_clk, i_rst_n, $past(i_rst_n), r_active_id >= $past(r_active_id), "request id went backwards")

    // the owner state only moves on a decision step
    `COHG_ASSERT_NOW(a_mode_on_step, i_clk, i_rst_n, $past(i_rst_n) && (r_mode != $past(r_mode)), $past(w_step), "owner state changed without a beat")

    // a completed release leaves the manual owner in charge
    `COHG_ASSERT_NEXT(a_release_manual, i_clk, i_rst_n, w_step && (n_status == ST_RELEASED), r_mode == MODE_MANUAL && r_out_mode == CODE_MANUAL, "release did not return to manual")

    // every new result comes from a held request
    `COHG_ASSERT_NOW(a_result_source, i_clk, i_rst_n, $past(i_rst_n) && $rose(r_out_valid), $past(r_in_valid), "result without a request")

endmodule
